/* design/etis_pkg.sv */
// ============================================================================
// etis_pkg
// Shared types, constants and helpers for the edge timestamp interval
// statistics unit.
// ============================================================================
package etis_pkg;

  localparam int DEPTH   = 128;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int STAMP_W = 64;
  localparam int STAT_W  = 32;
  localparam int STEP_W  = $clog2(STAMP_W);

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               start;
    logic [STAMP_W-1:0] dividend;
    logic [CNT_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [STAMP_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [STAT_W-1:0] sat32(input logic [STAMP_W-1:0] v);
    logic [STAT_W-1:0] r;
    if (v > STAMP_W'({STAT_W{1'b1}})) begin
      r = '1;
    end else begin
      r = v[STAT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] sat_count(input logic [CNT_W-1:0] n);
    logic [7:0] r;
    if (32'(n) > 32'd255) begin
      r = 8'hFF;
    end else begin
      r = 8'(n);
    end
    return r;
  endfunction

endpackage

/* design/etis_if.sv */
// ============================================================================
// etis_if
// Channel interfaces: edge events and queries in, statistics out.
// ============================================================================
interface etis_item_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [etis_pkg::STAMP_W-1:0]    stamp_us;
  logic                            pin_level;
  logic                            clear_after;

  modport source (output valid, op, stamp_us, pin_level, clear_after, input ready);
  modport sink   (input valid, op, stamp_us, pin_level, clear_after, output ready);
endinterface

interface etis_stats_if;
  logic                           valid;
  logic                           ready;
  logic                           is_empty;
  logic [7:0]                     stamp_count;
  logic [etis_pkg::STAT_W-1:0]    overwrite_count;
  logic                           last_level;
  logic [etis_pkg::STAT_W-1:0]    min_interval_us;
  logic [etis_pkg::STAT_W-1:0]    avg_interval_us;
  logic [etis_pkg::STAT_W-1:0]    max_interval_us;

  modport source (output valid, is_empty, stamp_count, overwrite_count, last_level,
                  min_interval_us, avg_interval_us, max_interval_us, input ready);
  modport sink   (input valid, is_empty, stamp_count, overwrite_count, last_level,
                  min_interval_us, avg_interval_us, max_interval_us, output ready);
endinterface

/* design/etis_ram.sv */
// ============================================================================
// etis_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module etis_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/etis_div.sv */
// ============================================================================
// etis_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ============================================================================
module etis_div (
  input  logic               clk,
  input  logic               rst,
  input  etis_pkg::div_req_t req,
  output etis_pkg::div_rsp_t rsp
);

  logic                           busy;
  logic                           done;
  logic [etis_pkg::STEP_W-1:0]    step;
  logic [etis_pkg::STAMP_W-1:0]   quo;
  logic [etis_pkg::CNT_W-1:0]     rem;
  logic [etis_pkg::CNT_W-1:0]     dsor;
  logic [etis_pkg::CNT_W:0]       rem_shift;
  logic                           qbit;
  logic [etis_pkg::CNT_W:0]       rem_diff;

  always_comb begin
    rem_shift = {rem, quo[etis_pkg::STAMP_W-1]};
    qbit      = rem_shift >= {1'b0, dsor};
    rem_diff  = rem_shift - {1'b0, dsor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        quo  <= req.dividend;
        dsor <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        quo  <= {quo[etis_pkg::STAMP_W-2:0], qbit};
        rem  <= qbit ? rem_diff[etis_pkg::CNT_W-1:0] : rem_shift[etis_pkg::CNT_W-1:0];
        step <= step + 1'b1;
        if (step == etis_pkg::STEP_W'(etis_pkg::STAMP_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* design/edge_timestamp_interval_stats_unit.sv */
// ============================================================================
// edge_timestamp_interval_stats_unit
// Edge timestamp ring with min, average and max interval statistics.
//
//   Channel  Role   Beat contents
//   item     sink   op, stamp_us, pin_level, clear_after
//   stats    source is_empty, stamp_count, overwrite_count, last_level,
//                   min/avg/max_interval_us
//
// An edge event writes the stamp RAM directly.
// A query walks the stored stamps through the RAM read port, one per cycle,
// and then runs the bit-serial divider when two or more stamps are stored.
// Reset is synchronous and needs no clearing pass; the ring is read only
// where it was written. Events are still taken while a result waits.
// ============================================================================
module edge_timestamp_interval_stats_unit (
  input  logic                clk,
  input  logic                rst,
  etis_item_if.sink           item,
  etis_stats_if.source        stats
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DIV
  } state_t;

  state_t                        state;
  logic [etis_pkg::PTR_W-1:0]    wp;
  logic [etis_pkg::CNT_W-1:0]    cnt;
  logic [etis_pkg::STAT_W-1:0]   ovf;
  logic                          lvl;
  logic [etis_pkg::CNT_W-1:0]    n_q;
  logic [etis_pkg::CNT_W-1:0]    iss;
  logic [etis_pkg::PTR_W-1:0]    rd_idx;
  logic                          pend;
  logic                          have_first;
  logic [etis_pkg::STAMP_W-1:0]  first_s;
  logic [etis_pkg::STAMP_W-1:0]  prev_s;
  logic [etis_pkg::STAMP_W-1:0]  mn;
  logic [etis_pkg::STAMP_W-1:0]  mx;
  logic                          clr_q;
  logic                          res_valid;

  logic                          accept;
  logic                          rd_en;
  logic                          walk_end;
  logic                          finish;
  logic [etis_pkg::STAT_W-1:0]   avg_val;
  logic [etis_pkg::CNT_W-1:0]    wp_ext;
  logic [etis_pkg::CNT_W-1:0]    start_idx;
  logic [etis_pkg::STAMP_W-1:0]  rdata;
  logic [etis_pkg::STAMP_W-1:0]  dt;
  etis_pkg::div_req_t            div_req;
  etis_pkg::div_rsp_t            div_rsp;

  assign item.ready = (state == S_IDLE) && (!res_valid || item.op == etis_pkg::OP_EVENT);
  assign accept     = item.valid && item.ready;

  always_comb begin
    wp_ext = etis_pkg::CNT_W'(wp);
    if (wp_ext >= cnt) begin
      start_idx = wp_ext - cnt;
    end else begin
      start_idx = wp_ext + etis_pkg::CNT_W'(etis_pkg::DEPTH) - cnt;
    end
    rd_en    = (state == S_WALK) && (iss != n_q);
    walk_end = (state == S_WALK) && (iss == n_q) && !pend;
    dt       = rdata - prev_s;
    div_req.start    = walk_end && (n_q > etis_pkg::CNT_W'(1));
    div_req.dividend = prev_s - first_s;
    div_req.divisor  = n_q - 1'b1;
    finish  = (walk_end && (n_q <= etis_pkg::CNT_W'(1))) || ((state == S_DIV) && div_rsp.done);
    avg_val = (state == S_DIV) ? etis_pkg::sat32(div_rsp.quotient) : '0;
  end

  etis_ram #(
    .WIDTH (etis_pkg::STAMP_W),
    .DEPTH (etis_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && item.op == etis_pkg::OP_EVENT),
    .waddr (wp),
    .wdata (item.stamp_us),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  etis_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      cnt       <= '0;
      ovf       <= '0;
      lvl       <= 1'b1;
      iss       <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      pend <= rd_en;
      case (state)
        S_IDLE: begin
          if (accept && item.op == etis_pkg::OP_EVENT) begin
            lvl <= item.pin_level;
            wp  <= (wp == etis_pkg::PTR_W'(etis_pkg::DEPTH - 1)) ? '0 : wp + 1'b1;
            if (cnt < etis_pkg::CNT_W'(etis_pkg::DEPTH)) begin
              cnt <= cnt + 1'b1;
            end else if (ovf != '1) begin
              ovf <= ovf + 1'b1;
            end
          end else if (accept) begin
            state      <= S_WALK;
            n_q        <= cnt;
            clr_q      <= item.clear_after;
            iss        <= '0;
            rd_idx     <= etis_pkg::PTR_W'(start_idx);
            have_first <= 1'b0;
            mn         <= '1;
            mx         <= '0;
          end
        end
        S_WALK: begin
          if (rd_en) begin
            iss    <= iss + 1'b1;
            rd_idx <= (rd_idx == etis_pkg::PTR_W'(etis_pkg::DEPTH - 1)) ? '0 : rd_idx + 1'b1;
          end
          if (pend) begin
            prev_s     <= rdata;
            have_first <= 1'b1;
            if (!have_first) begin
              first_s <= rdata;
            end else begin
              if (dt < mn) begin
                mn <= dt;
              end
              if (dt > mx) begin
                mx <= dt;
              end
            end
          end
          if (div_req.start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (finish) begin
        state                 <= S_IDLE;
        res_valid             <= 1'b1;
        stats.is_empty        <= (n_q == '0);
        stats.stamp_count     <= etis_pkg::sat_count(n_q);
        stats.overwrite_count <= ovf;
        stats.last_level      <= lvl;
        stats.min_interval_us <= etis_pkg::sat32(mn);
        stats.avg_interval_us <= avg_val;
        stats.max_interval_us <= etis_pkg::sat32(mx);
        if (clr_q) begin
          cnt <= '0;
          ovf <= '0;
        end
      end else if (stats.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign stats.valid = res_valid;

endmodule

/* design/etis_chk.sv */
// ============================================================================
// etis_chk
// Port-level checks on the statistics results, bound to the top level.
// ============================================================================
module etis_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          stats_valid,
  input logic                          stats_ready,
  input logic                          is_empty,
  input logic [7:0]                    stamp_count,
  input logic [etis_pkg::STAT_W-1:0]   overwrite_count,
  input logic [etis_pkg::STAT_W-1:0]   min_interval_us,
  input logic [etis_pkg::STAT_W-1:0]   avg_interval_us,
  input logic [etis_pkg::STAT_W-1:0]   max_interval_us
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !stats_valid)
    else $error("result shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    stats_valid && !stats_ready |=> stats_valid && $stable(stamp_count)
      && $stable(overwrite_count) && $stable(min_interval_us)
      && $stable(avg_interval_us) && $stable(max_interval_us))
    else $error("stalled result beat changed");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    stats_valid |-> is_empty == (stamp_count == 8'd0))
    else $error("empty flag disagrees with stamp count");

  a_few_stamps: assert property (@(posedge clk) disable iff (rst)
    stats_valid && (stamp_count == 8'd0 || stamp_count == 8'd1) |->
      min_interval_us == '1 && avg_interval_us == '0 && max_interval_us == '0)
    else $error("interval fields wrong with fewer than two stamps");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    stats_valid && stamp_count > 8'd1 |-> min_interval_us <= max_interval_us)
    else $error("minimum interval above maximum");

endmodule

bind edge_timestamp_interval_stats_unit etis_chk u_etis_chk (
  .clk             (clk),
  .rst             (rst),
  .stats_valid     (stats.valid),
  .stats_ready     (stats.ready),
  .is_empty        (stats.is_empty),
  .stamp_count     (stats.stamp_count),
  .overwrite_count (stats.overwrite_count),
  .min_interval_us (stats.min_interval_us),
  .avg_interval_us (stats.avg_interval_us),
  .max_interval_us (stats.max_interval_us)
);

/* tb/sv/tb_top.sv */
// ============================================================================
// tb_top
// Self-checking bench for the edge timestamp interval statistics unit.
// Edge beats and query beats are fed through the item channel. A ring
// predictor mirrors the stamp store, the counters and the pin level, and
// works out the statistics beat that each query must return. Each beat on
// the stats channel is checked field by field against the oldest prediction.
// Both sides of the design idle and stall at random.
// ============================================================================
module tb_top;

  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned DRAIN_CYCLES  = 300;
  localparam int unsigned RANDOM_BEATS  = 1800;
  localparam int unsigned PRINT_CAP     = 60;

  typedef struct {
    logic                         op;
    logic [etis_pkg::STAMP_W-1:0] stamp_us;
    logic                         pin_level;
    logic                         clear_after;
    bit                           hold_for_drain;
  } item_beat_t;

  typedef struct {
    logic                        is_empty;
    logic [7:0]                  stamp_count;
    logic [etis_pkg::STAT_W-1:0] overwrite_count;
    logic                        last_level;
    logic [etis_pkg::STAT_W-1:0] min_interval_us;
    logic [etis_pkg::STAT_W-1:0] avg_interval_us;
    logic [etis_pkg::STAT_W-1:0] max_interval_us;
  } stats_beat_t;

  logic clk = 1'b0;
  logic rst;

  etis_item_if  item_ch ();
  etis_stats_if stats_ch ();

  edge_timestamp_interval_stats_unit u_top (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .stats (stats_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_beat_t  pending_beats[$];
  stats_beat_t stats_due[$];

  bit [etis_pkg::STAMP_W-1:0] ring_stamps [etis_pkg::DEPTH];
  int unsigned                ring_wr_ptr;
  int unsigned                ring_count;
  bit [etis_pkg::STAT_W-1:0]  ring_overwrites;
  bit                         ring_level;

  int unsigned mismatch_count;
  int unsigned edge_total;
  int unsigned query_total;
  int unsigned clear_total;
  int unsigned saturated_total;
  int unsigned wrap_total;
  int unsigned peak_overwrites;
  int unsigned cycle_count;

  item_beat_t  cur_beat;
  bit          have_item;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned open_left;

  function automatic bit [etis_pkg::STAT_W-1:0] clamp_stat(
      input bit [etis_pkg::STAMP_W-1:0] v);
    if (v > {{(etis_pkg::STAMP_W-etis_pkg::STAT_W){1'b0}}, {etis_pkg::STAT_W{1'b1}}}) begin
      return '1;
    end
    return v[etis_pkg::STAT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [etis_pkg::STAMP_W-1:0] got,
                                 input logic [etis_pkg::STAMP_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("MISMATCH cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    end
  endtask

  task automatic ring_accept(input item_beat_t b);
    stats_beat_t                s;
    bit [etis_pkg::STAMP_W-1:0] lo;
    bit [etis_pkg::STAMP_W-1:0] hi;
    bit [etis_pkg::STAMP_W-1:0] first;
    bit [etis_pkg::STAMP_W-1:0] prev;
    bit [etis_pkg::STAMP_W-1:0] cur;
    bit [etis_pkg::STAMP_W-1:0] dt;
    bit [etis_pkg::STAMP_W-1:0] mean;
    int unsigned                n;
    int unsigned                idx;
    if (b.op == etis_pkg::OP_EVENT) begin
      edge_total++;
      ring_level = b.pin_level;
      ring_stamps[ring_wr_ptr] = b.stamp_us;
      ring_wr_ptr = (ring_wr_ptr + 1) % etis_pkg::DEPTH;
      if (ring_count < etis_pkg::DEPTH) begin
        ring_count++;
      end else if (ring_overwrites != '1) begin
        ring_overwrites++;
      end
      if (ring_overwrites > peak_overwrites) begin
        peak_overwrites = ring_overwrites;
      end
    end else begin
      query_total++;
      n = (ring_count > etis_pkg::DEPTH) ? etis_pkg::DEPTH : ring_count;
      lo = '1;
      hi = '0;
      mean = '0;
      first = '0;
      prev = '0;
      for (int unsigned i = 0; i < n; i++) begin
        idx = (ring_wr_ptr + etis_pkg::DEPTH - n + i) % etis_pkg::DEPTH;
        cur = ring_stamps[idx];
        if (i == 0) begin
          first = cur;
        end else begin
          if (cur < prev) begin
            wrap_total++;
          end
          dt = cur - prev;
          if (dt < lo) lo = dt;
          if (dt > hi) hi = dt;
        end
        prev = cur;
      end
      if (n > 1) begin
        mean = (prev - first) / etis_pkg::STAMP_W'(n - 1);
      end
      s.is_empty        = (n == 0);
      s.stamp_count     = (n > 255) ? 8'hFF : 8'(n);
      s.overwrite_count = ring_overwrites;
      s.last_level      = ring_level;
      s.min_interval_us = clamp_stat(lo);
      s.avg_interval_us = clamp_stat(mean);
      s.max_interval_us = clamp_stat(hi);
      if (n > 1 &&
          (hi > {{(etis_pkg::STAMP_W-etis_pkg::STAT_W){1'b0}}, {etis_pkg::STAT_W{1'b1}}})) begin
        saturated_total++;
      end
      stats_due.push_back(s);
      if (b.clear_after) begin
        clear_total++;
        ring_count = 0;
        ring_overwrites = '0;
      end
    end
  endtask

  task automatic check_stats();
    stats_beat_t want;
    if (stats_due.size() == 0) begin
      report_mismatch("stats beat with nothing due", '0, '0);
      return;
    end
    want = stats_due.pop_front();
    if (stats_ch.is_empty !== want.is_empty)
      report_mismatch("is_empty", etis_pkg::STAMP_W'(stats_ch.is_empty),
                      etis_pkg::STAMP_W'(want.is_empty));
    if (stats_ch.stamp_count !== want.stamp_count)
      report_mismatch("stamp_count", etis_pkg::STAMP_W'(stats_ch.stamp_count),
                      etis_pkg::STAMP_W'(want.stamp_count));
    if (stats_ch.overwrite_count !== want.overwrite_count)
      report_mismatch("overwrite_count", etis_pkg::STAMP_W'(stats_ch.overwrite_count),
                      etis_pkg::STAMP_W'(want.overwrite_count));
    if (stats_ch.last_level !== want.last_level)
      report_mismatch("last_level", etis_pkg::STAMP_W'(stats_ch.last_level),
                      etis_pkg::STAMP_W'(want.last_level));
    if (stats_ch.min_interval_us !== want.min_interval_us)
      report_mismatch("min_interval_us", etis_pkg::STAMP_W'(stats_ch.min_interval_us),
                      etis_pkg::STAMP_W'(want.min_interval_us));
    if (stats_ch.avg_interval_us !== want.avg_interval_us)
      report_mismatch("avg_interval_us", etis_pkg::STAMP_W'(stats_ch.avg_interval_us),
                      etis_pkg::STAMP_W'(want.avg_interval_us));
    if (stats_ch.max_interval_us !== want.max_interval_us)
      report_mismatch("max_interval_us", etis_pkg::STAMP_W'(stats_ch.max_interval_us),
                      etis_pkg::STAMP_W'(want.max_interval_us));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      have_item = 1'b0;
      burst_left = 0;
      gap_left = 0;
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        ring_accept(cur_beat);
        have_item = 1'b0;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(0, 12);
          gap_left = $urandom_range(1, 8);
        end
      end
      if (!have_item && pending_beats.size() != 0 &&
          !(pending_beats[0].hold_for_drain && stats_due.size() != 0)) begin
        cur_beat = pending_beats.pop_front();
        have_item = 1'b1;
      end
      if (gap_left != 0) begin
        gap_left--;
        item_ch.valid <= 1'b0;
      end else begin
        item_ch.valid <= have_item;
      end
      item_ch.op          <= cur_beat.op;
      item_ch.stamp_us    <= cur_beat.stamp_us;
      item_ch.pin_level   <= cur_beat.pin_level;
      item_ch.clear_after <= cur_beat.clear_after;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      open_left = 0;
      stats_ch.ready <= 1'b0;
    end else begin
      if (stats_ch.valid && stats_ch.ready) begin
        check_stats();
      end
      if (stall_left != 0) begin
        stall_left--;
        stats_ch.ready <= 1'b0;
      end else begin
        stats_ch.ready <= 1'b1;
        if (open_left != 0) begin
          open_left--;
        end else begin
          open_left = $urandom_range(0, 60);
          stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 3);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d beats pending and %0d results due",
               cycle_count, pending_beats.size(), stats_due.size());
      $display("edge_timestamp_interval_stats_unit verification failed");
      $finish;
    end
  end

  task automatic queue_edge(input logic [etis_pkg::STAMP_W-1:0] stamp, input logic lvl);
    item_beat_t b;
    b.op = etis_pkg::OP_EVENT;
    b.stamp_us = stamp;
    b.pin_level = lvl;
    b.clear_after = 1'($urandom_range(0, 1));
    b.hold_for_drain = 1'b0;
    pending_beats.push_back(b);
  endtask

  task automatic queue_query(input logic clr, input bit hold);
    item_beat_t b;
    b.op = etis_pkg::OP_QUERY;
    b.stamp_us = {$urandom, $urandom};
    b.pin_level = 1'($urandom_range(0, 1));
    b.clear_after = clr;
    b.hold_for_drain = hold;
    pending_beats.push_back(b);
  endtask

  initial begin
    bit [etis_pkg::STAMP_W-1:0] now_us;
    bit [etis_pkg::STAMP_W-1:0] delta;
    int unsigned                queued;
    int unsigned                run_len;
    int unsigned                style;
    int unsigned                next_hold;

    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.op = etis_pkg::OP_EVENT;
    item_ch.stamp_us = '0;
    item_ch.pin_level = 1'b0;
    item_ch.clear_after = 1'b0;
    stats_ch.ready = 1'b0;
    cur_beat = '{etis_pkg::OP_EVENT, '0, 1'b0, 1'b0, 1'b0};
    ring_wr_ptr = 0;
    ring_count = 0;
    ring_overwrites = '0;
    ring_level = 1'b1;

    // Empty ring, a single stamp, wrap across zero, exact and over saturation.
    queue_query(1'b0, 1'b0);
    queue_query(1'b1, 1'b0);
    queue_edge(64'h0, 1'b0);
    queue_query(1'b0, 1'b0);
    queue_edge(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    queue_edge(64'h4, 1'b0);
    queue_query(1'b0, 1'b0);
    queue_edge(64'h4 + 64'hFFFF_FFFF, 1'b1);
    queue_edge(64'h4 + 64'hFFFF_FFFF + 64'h1_0000_0000, 1'b1);
    queue_edge(64'h4 + 64'hFFFF_FFFF + 64'h1_0000_0000, 1'b0);
    queue_query(1'b1, 1'b1);
    queue_query(1'b0, 1'b0);
    queue_edge(64'h8000_0000_0000_0000, 1'b0);
    queue_edge(64'h8000_0000_0000_0001, 1'b1);
    queue_query(1'b0, 1'b0);

    queued = 0;
    next_hold = 400;
    now_us = {$urandom, $urandom};
    while (queued < RANDOM_BEATS) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_query(1'($urandom_range(0, 1)), 1'b0);
        queued++;
      end else begin
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 170)
                                              : $urandom_range(0, 12);
        style = $urandom_range(0, 3);
        for (int unsigned i = 0; i < run_len; i++) begin
          case (style)
            0: begin
              delta = etis_pkg::STAMP_W'($urandom_range(0, 2000));
              now_us = now_us + delta;
            end
            1: begin
              delta = {30'd0, 2'($urandom_range(0, 3)), $urandom};
              now_us = now_us + delta;
            end
            2: begin
              now_us = {$urandom, $urandom};
            end
            default: begin
              delta = etis_pkg::STAMP_W'($urandom_range(0, 3));
              now_us = now_us + delta;
            end
          endcase
          queue_edge(now_us, 1'($urandom_range(0, 1)));
        end
        queued += run_len;
        queue_query($urandom_range(0, 3) == 0, queued >= next_hold);
        if (queued >= next_hold) begin
          next_hold += 400;
        end
        queued++;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || have_item || stats_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d edge beats and %0d queries, %0d of them clearing.",
             edge_total, query_total, clear_total);
    $display("Peak overwrites %0d, %0d wrapped intervals, %0d saturated max intervals.",
             peak_overwrites, wrap_total, saturated_total);
    if (mismatch_count == 0) begin
      $display("edge_timestamp_interval_stats_unit verification clean");
    end else begin
      $display("%0d mismatches found", mismatch_count);
      $display("edge_timestamp_interval_stats_unit verification failed");
    end
    $finish;
  end

endmodule
